// ===== rtl/scfc_pkg.sv =====
// Shared constants, types and the compare microprogram for the caseless compare block.
package scfc_pkg;

   localparam int MAX_LEN  = 256;
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DIFF_W   = 10;
   localparam int DIFF_MAX = 256;
   localparam int DL_W     = ((LEN_W > DIFF_W) ? LEN_W : DIFF_W) + 2;
   localparam int TDATA_IN_W  = 16;
   localparam int TDATA_OUT_W = 16;

   // request commands
   localparam logic [1:0] CMD_APPEND_A = 2'd0;
   localparam logic [1:0] CMD_APPEND_B = 2'd1;
   localparam logic [1:0] CMD_COMPARE  = 2'd2;

   // microprogram
   localparam int STEP_W = 4;
   localparam int COND_W = 3;
   localparam int ACT_W  = 4;

   localparam logic [STEP_W-1:0] STEP_LA_RD  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LA_CHK = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LB_RD  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_LB_CHK = 4'd3;
   localparam logic [STEP_W-1:0] STEP_TA_RD  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_TA_CHK = 4'd5;
   localparam logic [STEP_W-1:0] STEP_TB_RD  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_TB_CHK = 4'd7;
   localparam logic [STEP_W-1:0] STEP_M_RD   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_M_CHK  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_M_WS   = 4'd10;
   localparam logic [STEP_W-1:0] STEP_SA_RD  = 4'd11;
   localparam logic [STEP_W-1:0] STEP_SA_CHK = 4'd12;
   localparam logic [STEP_W-1:0] STEP_SB_RD  = 4'd13;
   localparam logic [STEP_W-1:0] STEP_SB_CHK = 4'd14;
   localparam logic [STEP_W-1:0] STEP_DONE   = 4'd15;

   localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd0;
   localparam logic [COND_W-1:0] COND_A_EMPTY   = 3'd1;
   localparam logic [COND_W-1:0] COND_B_EMPTY   = 3'd2;
   localparam logic [COND_W-1:0] COND_ANY_EMPTY = 3'd3;
   localparam logic [COND_W-1:0] COND_WS_A      = 3'd4;
   localparam logic [COND_W-1:0] COND_WS_B      = 3'd5;
   localparam logic [COND_W-1:0] COND_MISMATCH  = 3'd6;

   localparam logic [ACT_W-1:0] ACT_NOP       = 4'd0;
   localparam logic [ACT_W-1:0] ACT_INC_IA    = 4'd1;
   localparam logic [ACT_W-1:0] ACT_INC_IB    = 4'd2;
   localparam logic [ACT_W-1:0] ACT_DEC_EA    = 4'd3;
   localparam logic [ACT_W-1:0] ACT_DEC_EB    = 4'd4;
   localparam logic [ACT_W-1:0] ACT_INC_BOTH  = 4'd5;
   localparam logic [ACT_W-1:0] ACT_DIFF_BYTE = 4'd6;
   localparam logic [ACT_W-1:0] ACT_DIFF_LEN  = 4'd7;
   localparam logic [ACT_W-1:0] ACT_FINISH    = 4'd8;

   typedef struct packed {
      logic              rd_a;
      logic              rd_b;
      logic              tail;
      logic [COND_W-1:0] cond;
      logic [ACT_W-1:0]  act_t;
      logic [STEP_W-1:0] tgt_t;
      logic [ACT_W-1:0]  act_f;
      logic [STEP_W-1:0] tgt_f;
   } ucode_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

   function automatic ucode_type mk(input logic rd_a, input logic rd_b, input logic tail,
                                    input logic [COND_W-1:0] cond,
                                    input logic [ACT_W-1:0] act_t,
                                    input logic [STEP_W-1:0] tgt_t,
                                    input logic [ACT_W-1:0] act_f,
                                    input logic [STEP_W-1:0] tgt_f);
      ucode_type w;
      w.rd_a  = rd_a;
      w.rd_b  = rd_b;
      w.tail  = tail;
      w.cond  = cond;
      w.act_t = act_t;
      w.tgt_t = tgt_t;
      w.act_f = act_f;
      w.tgt_f = tgt_f;
      return w;
   endfunction

   // Read steps issue a buffer read; the following check step sees the data.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         // trim leading whitespace
         STEP_LA_RD:  w = mk(1'b1, 1'b0, 1'b0, COND_A_EMPTY, ACT_NOP, STEP_LB_RD,
                             ACT_NOP, STEP_LA_CHK);
         STEP_LA_CHK: w = mk(1'b0, 1'b0, 1'b0, COND_WS_A, ACT_INC_IA, STEP_LA_RD,
                             ACT_NOP, STEP_LB_RD);
         STEP_LB_RD:  w = mk(1'b0, 1'b1, 1'b0, COND_B_EMPTY, ACT_NOP, STEP_TA_RD,
                             ACT_NOP, STEP_LB_CHK);
         STEP_LB_CHK: w = mk(1'b0, 1'b0, 1'b0, COND_WS_B, ACT_INC_IB, STEP_LB_RD,
                             ACT_NOP, STEP_TA_RD);
         // trim trailing whitespace
         STEP_TA_RD:  w = mk(1'b1, 1'b0, 1'b1, COND_A_EMPTY, ACT_NOP, STEP_TB_RD,
                             ACT_NOP, STEP_TA_CHK);
         STEP_TA_CHK: w = mk(1'b0, 1'b0, 1'b0, COND_WS_A, ACT_DEC_EA, STEP_TA_RD,
                             ACT_NOP, STEP_TB_RD);
         STEP_TB_RD:  w = mk(1'b0, 1'b1, 1'b1, COND_B_EMPTY, ACT_NOP, STEP_M_RD,
                             ACT_NOP, STEP_TB_CHK);
         STEP_TB_CHK: w = mk(1'b0, 1'b0, 1'b0, COND_WS_B, ACT_DEC_EB, STEP_TB_RD,
                             ACT_NOP, STEP_M_RD);
         // main walk
         STEP_M_RD:   w = mk(1'b1, 1'b1, 1'b0, COND_ANY_EMPTY, ACT_DIFF_LEN, STEP_DONE,
                             ACT_NOP, STEP_M_CHK);
         STEP_M_CHK:  w = mk(1'b0, 1'b0, 1'b0, COND_MISMATCH, ACT_DIFF_BYTE, STEP_DONE,
                             ACT_INC_BOTH, STEP_M_WS);
         STEP_M_WS:   w = mk(1'b0, 1'b0, 1'b0, COND_WS_A, ACT_NOP, STEP_SA_RD,
                             ACT_NOP, STEP_M_RD);
         // collapse whitespace runs after a matching whitespace byte
         STEP_SA_RD:  w = mk(1'b1, 1'b0, 1'b0, COND_A_EMPTY, ACT_NOP, STEP_SB_RD,
                             ACT_NOP, STEP_SA_CHK);
         STEP_SA_CHK: w = mk(1'b0, 1'b0, 1'b0, COND_WS_A, ACT_INC_IA, STEP_SA_RD,
                             ACT_NOP, STEP_SB_RD);
         STEP_SB_RD:  w = mk(1'b0, 1'b1, 1'b0, COND_B_EMPTY, ACT_NOP, STEP_M_RD,
                             ACT_NOP, STEP_SB_CHK);
         STEP_SB_CHK: w = mk(1'b0, 1'b0, 1'b0, COND_WS_B, ACT_INC_IB, STEP_SB_RD,
                             ACT_NOP, STEP_M_RD);
         STEP_DONE:   w = mk(1'b0, 1'b0, 1'b0, COND_ALWAYS, ACT_FINISH, STEP_LA_RD,
                             ACT_FINISH, STEP_LA_RD);
         default:     w = mk(1'b0, 1'b0, 1'b0, COND_ALWAYS, ACT_FINISH, STEP_LA_RD,
                             ACT_FINISH, STEP_LA_RD);
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/scfc_strbuf.sv =====
// String buffer: one write port and one registered read port.
module scfc_strbuf (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [scfc_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic                       rd_en,
   input  logic [scfc_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                 rd_data
);

   logic [7:0] mem [scfc_pkg::MAX_LEN];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/space_folding_caseless_compare.sv =====
// Appends are accepted back to back while no compare is running.
// A compare runs a 16-step microprogram: it trims leading and trailing whitespace from
// both strings, walks them comparing case-folded bytes, and collapses whitespace runs
// after each matching whitespace byte; the finish step waits for a free output register.
// No request is taken during a compare; the result sits in the output register until taken.
// Synchronous reset clears lengths, the overflow flag and the sequencer; buffer contents
// are left as they are and are only read below the current lengths.
module space_folding_caseless_compare (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] command, [9:2] data_byte, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [9:0] difference, [10] overflow, [15:11] zero
);

   localparam int LW = scfc_pkg::LEN_W;
   localparam int AW = scfc_pkg::ADDR_W;
   localparam int DLW = scfc_pkg::DL_W;

   logic [1:0] cmd;
   logic [7:0] byte_in;
   logic       accept;

   logic          busy_ff, busy_in;
   logic [scfc_pkg::STEP_W-1:0] pc_ff, pc_in;
   logic [LW-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] ia_ff, ia_in, ib_ff, ib_in, ea_ff, ea_in, eb_ff, eb_in;
   logic [scfc_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;

   scfc_pkg::ucode_type uw;
   logic                          cond_hit;
   logic [scfc_pkg::ACT_W-1:0]    act;
   logic [scfc_pkg::STEP_W-1:0]   nxt;

   logic          wr_a_en, wr_b_en, rd_a_en, rd_b_en;
   logic [AW-1:0] rd_a_addr, rd_b_addr;
   logic [7:0]    da, db, fa, fb;
   logic [LW-1:0] ea_m1, eb_m1, rem_a, rem_b;
   logic signed [DLW-1:0] dlen;
   logic          a_empty, b_empty, out_free;

   assign cmd        = req_tdata[1:0];
   assign byte_in    = req_tdata[9:2];
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;

   assign uw = scfc_pkg::ucode_rom(pc_ff);

   assign fa      = scfc_pkg::fold(da);
   assign fb      = scfc_pkg::fold(db);
   assign a_empty = ia_ff >= ea_ff;
   assign b_empty = ib_ff >= eb_ff;
   assign ea_m1   = ea_ff - LW'(1);
   assign eb_m1   = eb_ff - LW'(1);
   assign rem_a   = ea_ff - ia_ff;
   assign rem_b   = eb_ff - ib_ff;
   assign dlen    = $signed(DLW'(rem_b)) - $signed(DLW'(rem_a));
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (uw.cond)
         scfc_pkg::COND_ALWAYS:    cond_hit = 1'b1;
         scfc_pkg::COND_A_EMPTY:   cond_hit = a_empty;
         scfc_pkg::COND_B_EMPTY:   cond_hit = b_empty;
         scfc_pkg::COND_ANY_EMPTY: cond_hit = a_empty || b_empty;
         scfc_pkg::COND_WS_A:      cond_hit = scfc_pkg::is_ws(da);
         scfc_pkg::COND_WS_B:      cond_hit = scfc_pkg::is_ws(db);
         scfc_pkg::COND_MISMATCH:  cond_hit = fa != fb;
         default:                  cond_hit = 1'b1;
      endcase
   end

   assign act = cond_hit ? uw.act_t : uw.act_f;
   assign nxt = cond_hit ? uw.tgt_t : uw.tgt_f;

   assign wr_a_en   = accept && cmd == scfc_pkg::CMD_APPEND_A
                      && len_a_ff < LW'(scfc_pkg::MAX_LEN);
   assign wr_b_en   = accept && cmd == scfc_pkg::CMD_APPEND_B
                      && len_b_ff < LW'(scfc_pkg::MAX_LEN);
   assign rd_a_en   = busy_ff && uw.rd_a;
   assign rd_b_en   = busy_ff && uw.rd_b;
   assign rd_a_addr = uw.tail ? ea_m1[AW-1:0] : ia_ff[AW-1:0];
   assign rd_b_addr = uw.tail ? eb_m1[AW-1:0] : ib_ff[AW-1:0];

   scfc_strbuf u_buf_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (len_a_ff[AW-1:0]),
      .wr_data (byte_in),
      .rd_en   (rd_a_en),
      .rd_addr (rd_a_addr),
      .rd_data (da)
   );

   scfc_strbuf u_buf_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (len_b_ff[AW-1:0]),
      .wr_data (byte_in),
      .rd_en   (rd_b_en),
      .rd_addr (rd_b_addr),
      .rd_data (db)
   );

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      ovf_in       = ovf_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      ea_in        = ea_ff;
      eb_in        = eb_ff;
      diff_in      = diff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         case (cmd)
            scfc_pkg::CMD_APPEND_A: begin
               if (wr_a_en) len_a_in = len_a_ff + LW'(1);
               else         ovf_in   = 1'b1;
            end
            scfc_pkg::CMD_APPEND_B: begin
               if (wr_b_en) len_b_in = len_b_ff + LW'(1);
               else         ovf_in   = 1'b1;
            end
            scfc_pkg::CMD_COMPARE: begin
               busy_in = 1'b1;
               pc_in   = scfc_pkg::STEP_LA_RD;
               ia_in   = '0;
               ib_in   = '0;
               ea_in   = len_a_ff;
               eb_in   = len_b_ff;
            end
            default: begin
            end
         endcase
      end

      if (busy_ff) begin
         pc_in = nxt;
         case (act)
            scfc_pkg::ACT_NOP: begin
            end
            scfc_pkg::ACT_INC_IA: ia_in = ia_ff + LW'(1);
            scfc_pkg::ACT_INC_IB: ib_in = ib_ff + LW'(1);
            scfc_pkg::ACT_DEC_EA: ea_in = ea_m1;
            scfc_pkg::ACT_DEC_EB: eb_in = eb_m1;
            scfc_pkg::ACT_INC_BOTH: begin
               ia_in = ia_ff + LW'(1);
               ib_in = ib_ff + LW'(1);
            end
            scfc_pkg::ACT_DIFF_BYTE: begin
               diff_in = {2'b00, fb} - {2'b00, fa};
            end
            scfc_pkg::ACT_DIFF_LEN: begin
               if (dlen > $signed(DLW'(scfc_pkg::DIFF_MAX))) begin
                  diff_in = scfc_pkg::DIFF_W'(scfc_pkg::DIFF_MAX);
               end else if (dlen < -$signed(DLW'(scfc_pkg::DIFF_MAX))) begin
                  diff_in = -scfc_pkg::DIFF_W'(scfc_pkg::DIFF_MAX);
               end else begin
                  diff_in = dlen[scfc_pkg::DIFF_W-1:0];
               end
            end
            scfc_pkg::ACT_FINISH: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {5'b00000, ovf_ff, diff_ff};
                  len_a_in     = '0;
                  len_b_in     = '0;
                  ovf_in       = 1'b0;
                  busy_in      = 1'b0;
               end else begin
                  pc_in = pc_ff;   // hold until the output register frees up
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= scfc_pkg::STEP_LA_RD;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      ea_ff       <= ea_in;
      eb_ff       <= eb_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_idle_pc: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> pc_ff == scfc_pkg::STEP_LA_RD)
      else $error("sequencer left step zero while idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff) == scfc_pkg::STEP_DONE)
      else $error("result raised outside the finish step");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_a_ff <= LW'(scfc_pkg::MAX_LEN) && len_b_ff <= LW'(scfc_pkg::MAX_LEN))
      else $error("string length beyond buffer size");

   a_window: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ia_ff <= ea_ff && ib_ff <= eb_ff
                  && ea_ff <= len_a_ff && eb_ff <= len_b_ff)
      else $error("compare window out of order");

endmodule

// ===== dv/tb_space_folding_caseless_compare.sv =====
// Testbench for the caseless, whitespace-folding string compare block.
module tb_space_folding_caseless_compare;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 300;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         DRAIN_CYCLES = 6 * scfc_pkg::MAX_LEN + 16;
   localparam int         CYCLE_LIMIT  = 1_000_000;

   typedef struct packed {
      logic signed [scfc_pkg::DIFF_W-1:0] difference;
      logic                               overflow;
   } verdict_type;

   typedef struct packed {
      logic        known;
      verdict_type value;
   } typed_verdict_type;

   typedef struct packed {
      logic [1:0]                         cmd;
      logic [7:0]                         data;
      logic [9:0]                         reps;
      logic                               known;
      logic signed [scfc_pkg::DIFF_W-1:0] diff;
      logic                               ovf;
   } stim_row_type;

   localparam int NUM_ROWS = 27;
   localparam stim_row_type DIRECTED [NUM_ROWS] = '{
      '{scfc_pkg::CMD_COMPARE,  8'h00, 10'd1, 1'b1, 10'sd0, 1'b0},    // both strings empty
      '{scfc_pkg::CMD_APPEND_A, 8'h00, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_B, 8'hFF, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_COMPARE,  8'hFF, 10'd1, 1'b1, 10'sd255, 1'b0},
      '{scfc_pkg::CMD_APPEND_A, 8'hFF, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_B, 8'h00, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_COMPARE,  8'h00, 10'd1, 1'b1, -10'sd255, 1'b0},
      // leading and trailing whitespace around a case-folded letter
      '{scfc_pkg::CMD_APPEND_A, 8'h20, 10'd2, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_A, 8'h51, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{CMD_UNUSED,             8'hAA, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_A, 8'h0D, 10'd3, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_B, 8'h09, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_B, 8'h71, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_B, 8'h0C, 10'd2, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_COMPARE,  8'h55, 10'd1, 1'b1, 10'sd0, 1'b0},
      // whitespace runs collapse after a matching whitespace byte
      '{scfc_pkg::CMD_APPEND_A, 8'h4B, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_A, 8'h0A, 10'd3, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_A, 8'h5A, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_B, 8'h6B, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_B, 8'h0A, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_B, 8'h20, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_APPEND_B, 8'h7A, 10'd1, 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_COMPARE,  8'hAA, 10'd1, 1'b0, 10'sd0, 1'b0},
      // full buffer, one byte dropped, lowest result; then a full B buffer, highest result
      '{scfc_pkg::CMD_APPEND_A, 8'h7E, 10'(scfc_pkg::MAX_LEN + 1), 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_COMPARE,  8'h00, 10'd1, 1'b1, -10'sd256, 1'b1},
      '{scfc_pkg::CMD_APPEND_B, 8'h41, 10'(scfc_pkg::MAX_LEN), 1'b0, 10'sd0, 1'b0},
      '{scfc_pkg::CMD_COMPARE,  8'h00, 10'd1, 1'b1, 10'sd256, 1'b0}
   };

   localparam logic [7:0] EDGE_BYTES [14] = '{
      8'h00, 8'h08, 8'h0E, 8'h1F, 8'h21, 8'h40, 8'h41,
      8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'hFF
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [1:0] command, [9:2] data_byte, [15:10] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [9:0] difference, [10] overflow, [15:11] zero

   space_folding_caseless_compare uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // predictor state
   logic [7:0] str_a [scfc_pkg::MAX_LEN];
   logic [7:0] str_b [scfc_pkg::MAX_LEN];
   int         len_a;
   int         len_b;
   logic       dropped;

   verdict_type       pending_verdicts [$];
   typed_verdict_type typed_verdicts [$];

   int sender_idle_pct;
   int receiver_stall_pct;
   int requests_sent;
   int requests_taken;
   int results_checked;
   int overflow_results;
   int failures;
   int cycles;
   int hold_left;
   int results_taken;
   bit hold_done;

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      rsp_tready         = 1'b0;
      len_a              = 0;
      len_b              = 0;
      dropped            = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      requests_sent      = 0;
      requests_taken     = 0;
      results_checked    = 0;
      overflow_results   = 0;
      failures           = 0;
      cycles             = 0;
      hold_left          = 0;
      results_taken      = 0;
      hold_done          = 1'b0;
   end

   always #1 clock = ~clock;

   function automatic bit is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c | 8'h20 : c;
   endfunction

   function automatic int compare_strings();
      int         ia;
      int         ib;
      int         ea;
      int         eb;
      logic [7:0] ca;
      logic [7:0] cb;
      ia = 0;
      ib = 0;
      ea = len_a;
      eb = len_b;
      while (ia < ea && is_space(str_a[ia])) ia++;
      while (ib < eb && is_space(str_b[ib])) ib++;
      while (ea > ia && is_space(str_a[ea-1])) ea--;
      while (eb > ib && is_space(str_b[eb-1])) eb--;
      while (ia < ea && ib < eb) begin
         ca = to_lower(str_a[ia]);
         cb = to_lower(str_b[ib]);
         if (ca != cb)
            return int'(cb) - int'(ca);
         ia++;
         ib++;
         if (is_space(ca)) begin
            while (ia < ea && is_space(str_a[ia])) ia++;
            while (ib < eb && is_space(str_b[ib])) ib++;
         end
      end
      return (eb - ib) - (ea - ia);
   endfunction

   function automatic bit predict_request(input logic [1:0] cmd, input logic [7:0] data,
                                          output verdict_type verdict);
      int d;
      verdict = '0;
      case (cmd)
         scfc_pkg::CMD_APPEND_A: begin
            if (len_a < scfc_pkg::MAX_LEN) begin
               str_a[len_a] = data;
               len_a++;
            end else begin
               dropped = 1'b1;
            end
         end
         scfc_pkg::CMD_APPEND_B: begin
            if (len_b < scfc_pkg::MAX_LEN) begin
               str_b[len_b] = data;
               len_b++;
            end else begin
               dropped = 1'b1;
            end
         end
         scfc_pkg::CMD_COMPARE: begin
            d = compare_strings();
            if (d > scfc_pkg::DIFF_MAX) d = scfc_pkg::DIFF_MAX;
            if (d < -scfc_pkg::DIFF_MAX) d = -scfc_pkg::DIFF_MAX;
            verdict.difference = d[scfc_pkg::DIFF_W-1:0];
            verdict.overflow   = dropped;
            len_a   = 0;
            len_b   = 0;
            dropped = 1'b0;
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // request and result monitor
   always @(posedge clock) begin : watch
      verdict_type       predicted;
      verdict_type       got;
      verdict_type       want;
      typed_verdict_type typed;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            requests_taken++;
            if (predict_request(req_tdata[1:0], req_tdata[9:2], predicted)) begin
               typed = '0;
               if (typed_verdicts.size() != 0)
                  typed = typed_verdicts.pop_front();
               pending_verdicts.push_back(typed.known ? typed.value : predicted);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.difference = rsp_tdata[scfc_pkg::DIFF_W-1:0];
            got.overflow   = rsp_tdata[scfc_pkg::DIFF_W];
            if (pending_verdicts.size() == 0) begin
               $error("unexpected result: difference %0d overflow %0b",
                      got.difference, got.overflow);
               failures++;
            end else begin
               want = pending_verdicts.pop_front();
               results_checked++;
               if (got.overflow) overflow_results++;
               if (got.difference !== want.difference) begin
                  $error("difference: expected %0d, got %0d",
                         want.difference, got.difference);
                  failures++;
               end
               if (got.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                  failures++;
               end
            end
         end
      end
   end

   // result receiver, with one long hold-off to back the block up
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) results_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_taken == 10) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $error("no progress: stopped after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic [7:0] data,
                               input logic known = 1'b0, input verdict_type typed = '0);
      if (cmd == scfc_pkg::CMD_COMPARE) typed_verdicts.push_back('{known, typed});
      if (cmd != CMD_UNUSED) requests_sent++;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, data, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [7:0] space_byte();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
   endfunction

   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         return (8'h41 + 8'($urandom_range(0, 25))) | ($urandom_range(1) ? 8'h20 : 8'h00);
      if (r < 65) return space_byte();
      if (r < 80) return 8'($urandom_range(8'h21, 8'h7E));
      if (r < 90) return EDGE_BYTES[$urandom_range(0, 13)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   // one string pair and its compare; a few calls send loose noise instead
   task automatic run_pair();
      logic [7:0] a_q [$];
      logic [7:0] b_q [$];
      logic [7:0] t_q [$];
      logic [7:0] c;
      int         r;
      int         n;
      int         pos;
      r = $urandom_range(99);
      if (r < 8) begin
         repeat ($urandom_range(1, 5)) send_request(2'($urandom_range(0, 3)), 8'($urandom));
         return;
      end
      if (r == 8) begin
         // long string near or past the buffer size against a short one
         n = $urandom_range(scfc_pkg::MAX_LEN - 16, scfc_pkg::MAX_LEN + 8);
         repeat (n) a_q.push_back(text_byte());
         repeat ($urandom_range(0, 4)) b_q.push_back(text_byte());
         if ($urandom_range(1)) begin
            a_q.reverse();
            b_q.reverse();
            t_q = a_q;
            a_q = b_q;
            b_q = t_q;
         end
      end else begin
         repeat ($urandom_range(0, 2)) a_q.push_back(space_byte());
         repeat ($urandom_range(0, 2)) b_q.push_back(space_byte());
         n = $urandom_range(0, 12);
         repeat (n) begin
            c = text_byte();
            a_q.push_back(c);
            b_q.push_back((is_letter(c) && $urandom_range(1)) ? c ^ 8'h20 : c);
            if (is_space(c)) begin
               repeat ($urandom_range(0, 2)) a_q.push_back(space_byte());
               repeat ($urandom_range(0, 2)) b_q.push_back(space_byte());
            end
         end
         repeat ($urandom_range(0, 2)) a_q.push_back(space_byte());
         repeat ($urandom_range(0, 2)) b_q.push_back(space_byte());
         if ($urandom_range(99) < 30) begin
            case ($urandom_range(0, 2))
               0: if (b_q.size() != 0) begin
                     pos = $urandom_range(0, b_q.size() - 1);
                     b_q[pos] = text_byte();
                  end
               1: if (b_q.size() != 0) void'(b_q.pop_back());
               default: b_q.push_back(text_byte());
            endcase
         end
      end
      while (a_q.size() != 0 || b_q.size() != 0) begin
         if (a_q.size() != 0 && (b_q.size() == 0 || $urandom_range(1)))
            send_request(scfc_pkg::CMD_APPEND_A, a_q.pop_front());
         else
            send_request(scfc_pkg::CMD_APPEND_B, b_q.pop_front());
         if ($urandom_range(99) < 2) send_request(CMD_UNUSED, 8'($urandom));
      end
      send_request(scfc_pkg::CMD_COMPARE, 8'($urandom));
   endtask

   initial begin : stimulus
      int directed_sent;
      int pair_count;
      int drain;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         repeat (DIRECTED[i].reps)
            send_request(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].known,
                         '{DIRECTED[i].diff, DIRECTED[i].ovf});
      end
      directed_sent = requests_sent;

      pair_count = 0;
      while (requests_sent < directed_sent + RANDOM_ITEMS) begin
         case ((pair_count / 3) % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase
         run_pair();
         pair_count++;
      end
      req_tvalid <= 1'b0;
      sender_idle_pct = 0;

      while (pending_verdicts.size() != 0 || typed_verdicts.size() != 0)
         @(posedge clock);
      drain = 0;
      while (drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end

      $display("Sent %0d requests in %0d string pairs; checked %0d compare results,",
               requests_taken, pair_count, results_checked);
      $display("%0d of them with dropped bytes; %0d mismatches.", overflow_results, failures);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
